// File: rtl/live_segment_window_manager_macros.svh
// Assertion macros for the live segment window manager.
`ifndef LIVE_SEGMENT_WINDOW_MANAGER_MACROS_SVH
`define LIVE_SEGMENT_WINDOW_MANAGER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LSWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LSWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lswm_pkg.sv
// Shared types, constants and command codes of the live segment window manager.
package lswm_pkg;

  localparam int WINDOW_DEPTH   = 16;
  localparam int RETAIN_DEPTH   = 16;
  localparam int WINDOW_TARGETS = 3;

  localparam int SEG_CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SEG_IW = $clog2(WINDOW_DEPTH);
  localparam int RET_CW = $clog2(RETAIN_DEPTH + 1);
  localparam int RET_IW = $clog2(RETAIN_DEPTH);

  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_MOVE    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_ENTRY   = 2'd3;

  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_KEEP   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [51:0] frame_time_us;
    logic [3:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [51:0] time_us;
    logic [51:0] entry_duration_us;
    logic [31:0] entry_sequence;
    logic [4:0]  entry_count;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_POP_FULL,
    OP_WRITE_SEG,
    OP_CAPF,
    OP_UNTIL_SPEC,
    OP_UNTIL_KEEP,
    OP_MUL,
    OP_UNTIL_TAIL,
    OP_PUSH_POP,
    OP_RET_POP,
    OP_RET_EMIT,
    OP_OPEN,
    OP_HOLD,
    OP_CLEAR,
    OP_RD_IDX,
    OP_ENTRY,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       open_nz;
    logic       close_ok;
    logic       seg_full;
    logic       cnt_gt1;
    logic       evict;
    logic       kc_neg;
    logic       kc_lt_cnt;
    logic       ret_nz;
    logic       expired;
  } sts_t;

endpackage

// File: rtl/lswm_ctrl.sv
// Sequencer of the live segment window manager: walks close, evict, retire and emit steps.
module lswm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lswm_pkg::sts_t sts,
  output lswm_pkg::cmd_t cmd,
  output logic          busy
);
  import lswm_pkg::*;

  localparam int ST_W = 22;

  typedef enum logic [ST_W-1:0] {
    S_IDLE  = ST_W'(1) << 0,
    S_KEY   = ST_W'(1) << 1,
    S_CFULL = ST_W'(1) << 2,
    S_CFPOP = ST_W'(1) << 3,
    S_CWR   = ST_W'(1) << 4,
    S_EWAIT = ST_W'(1) << 5,
    S_ECHK  = ST_W'(1) << 6,
    S_USPEC = ST_W'(1) << 7,
    S_UKEEP = ST_W'(1) << 8,
    S_UMUL  = ST_W'(1) << 9,
    S_UTAIL = ST_W'(1) << 10,
    S_PUSH  = ST_W'(1) << 11,
    S_RWAIT = ST_W'(1) << 12,
    S_RCHK  = ST_W'(1) << 13,
    S_RT    = ST_W'(1) << 14,
    S_REMIT = ST_W'(1) << 15,
    S_OPEN  = ST_W'(1) << 16,
    S_HOLD  = ST_W'(1) << 17,
    S_CLEAR = ST_W'(1) << 18,
    S_RIDX  = ST_W'(1) << 19,
    S_ENTRY = ST_W'(1) << 20,
    S_FLUSH = ST_W'(1) << 21
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          case (sts.req_type)
            REQ_KEY:   state_next = S_KEY;
            REQ_CLEAR: state_next = S_CLEAR;
            REQ_READ:  state_next = S_RIDX;
            default:   state_next = S_FLUSH;
          endcase
        end
      end
      S_KEY:   state_next = (sts.open_nz && sts.close_ok) ? S_CFULL : S_OPEN;
      S_CFULL: state_next = sts.seg_full ? S_CFPOP : S_CWR;
      S_CFPOP: begin
        cmd.op     = OP_POP_FULL;
        state_next = S_CWR;
      end
      S_CWR: begin
        cmd.op     = OP_WRITE_SEG;
        state_next = S_EWAIT;
      end
      S_EWAIT: state_next = S_ECHK;
      S_ECHK: begin
        if (!sts.cnt_gt1 || !sts.evict) begin
          state_next = S_RWAIT;
        end else begin
          cmd.op = OP_CAPF;
          if (sts.kc_neg) begin
            state_next = S_USPEC;
          end else if (sts.kc_lt_cnt) begin
            state_next = S_UKEEP;
          end else begin
            state_next = S_UMUL;
          end
        end
      end
      S_USPEC: begin
        cmd.op     = OP_UNTIL_SPEC;
        state_next = S_PUSH;
      end
      S_UKEEP: begin
        cmd.op     = OP_UNTIL_KEEP;
        state_next = S_PUSH;
      end
      S_UMUL: begin
        cmd.op     = OP_MUL;
        state_next = S_UTAIL;
      end
      S_UTAIL: begin
        cmd.op     = OP_UNTIL_TAIL;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.op     = OP_PUSH_POP;
        state_next = S_EWAIT;
      end
      S_RWAIT: state_next = S_RCHK;
      S_RCHK: begin
        if (sts.ret_nz && sts.expired) begin
          cmd.op     = OP_RET_POP;
          state_next = S_RT;
        end else begin
          state_next = S_OPEN;
        end
      end
      S_RT: state_next = S_REMIT;
      S_REMIT: begin
        cmd.op     = OP_RET_EMIT;
        state_next = S_RCHK;
      end
      S_OPEN: begin
        cmd.op     = OP_OPEN;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        cmd.op     = OP_HOLD;
        state_next = S_FLUSH;
      end
      S_CLEAR: begin
        cmd.op     = OP_CLEAR;
        state_next = S_FLUSH;
      end
      S_RIDX: begin
        cmd.op     = OP_RD_IDX;
        state_next = S_ENTRY;
      end
      S_ENTRY: begin
        cmd.op     = OP_ENTRY;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.op     = OP_FLUSH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/lswm_dp.sv
// Datapath of the live segment window manager: rings, totals, retention math and result queue.
module lswm_dp (
  input  logic            clk,
  input  logic            rst,
  input  lswm_pkg::cmd_t  cmd,
  input  lswm_pkg::req_t  req,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  output lswm_pkg::sts_t  sts,
  output lswm_pkg::res_t  result,
  output logic            result_strobe
);
  import lswm_pkg::*;

  localparam int LIM_W = 32 + $clog2(WINDOW_TARGETS + 1);

  typedef struct packed {
    logic [51:0] start;
    logic [51:0] dur;
    logic [31:0] seq;
  } seg_entry_t;

  typedef struct packed {
    logic [51:0] start;
    logic [51:0] keep_to;
  } ret_entry_t;

  function automatic logic [SEG_IW-1:0] seg_add(logic [SEG_IW-1:0] h, logic [SEG_CW-1:0] i);
    logic [SEG_CW:0] s;
    s = (SEG_CW + 1)'(h) + (SEG_CW + 1)'(i);
    if (s >= (SEG_CW + 1)'(WINDOW_DEPTH)) s = s - (SEG_CW + 1)'(WINDOW_DEPTH);
    return s[SEG_IW-1:0];
  endfunction

  function automatic logic [SEG_IW-1:0] seg_inc(logic [SEG_IW-1:0] h);
    return (h == SEG_IW'(WINDOW_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [RET_IW-1:0] ret_add(logic [RET_IW-1:0] h, logic [RET_CW-1:0] i);
    logic [RET_CW:0] s;
    s = (RET_CW + 1)'(h) + (RET_CW + 1)'(i);
    if (s >= (RET_CW + 1)'(RETAIN_DEPTH)) s = s - (RET_CW + 1)'(RETAIN_DEPTH);
    return s[RET_IW-1:0];
  endfunction

  function automatic logic [RET_IW-1:0] ret_inc(logic [RET_IW-1:0] h);
    return (h == RET_IW'(RETAIN_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [51:0] sat52(logic [58:0] v);
    return (|v[58:52]) ? '1 : v[51:0];
  endfunction

  logic [31:0]        target;
  logic signed [4:0]  keep;
  req_t               req_q;
  logic [55:0]        bak;

  seg_entry_t         seg_mem [WINDOW_DEPTH];
  seg_entry_t         seg_q, seg_wd;
  logic [SEG_IW-1:0]  seg_ra, seg_wa;
  logic               seg_we;
  ret_entry_t         ret_mem [RETAIN_DEPTH];
  ret_entry_t         ret_q, ret_wd;
  logic [RET_IW-1:0]  ret_wa;
  logic               ret_we;

  logic [SEG_IW-1:0]  seg_head;
  logic [SEG_CW-1:0]  seg_count;
  logic [RET_IW-1:0]  ret_head;
  logic [RET_CW-1:0]  ret_count;
  logic [55:0]        total;
  logic [51:0]        open_start;
  logic [31:0]        open_seq;
  logic [31:0]        seq_cnt;
  logic               hold;

  logic [51:0]        f_start, f_dur, keep_to;
  logic [52:0]        tsum;
  logic [55:0]        prod;

  logic               emit;
  res_t               new_res, pend, pend_fin;
  logic               pend_v;

  logic [51:0]        dur_open;
  logic [LIM_W-1:0]   limit;
  logic [56:0]        rest;
  logic [SEG_CW:0]    kc_diff;
  logic [58:0]        spec_sum, tail_sum;
  logic               idx_lt_cnt;
  logic               ret_full;
  logic [31:0]        seq_inc;

  assign dur_open   = req_q.frame_time_us - open_start;
  assign limit      = LIM_W'(target) * LIM_W'(WINDOW_TARGETS);
  assign rest       = {1'b0, total} - 57'(seg_q.dur);
  assign kc_diff    = (SEG_CW + 1)'(unsigned'(keep[3:0])) - (SEG_CW + 1)'(seg_count);
  assign spec_sum   = 59'(f_start) + 59'({f_dur, 1'b0}) + 59'(bak);
  assign tail_sum   = 59'(tsum) + 59'(prod);
  assign idx_lt_cnt = (SEG_CW + 1)'(req_q.entry_index) < (SEG_CW + 1)'(seg_count);
  assign ret_full   = (ret_count >= RET_CW'(RETAIN_DEPTH));
  assign seq_inc    = (seq_cnt == '1) ? 32'd1 : seq_cnt + 32'd1;

  always_comb begin
    sts.req_type  = req.req_type;
    sts.open_nz   = (open_seq != '0);
    sts.close_ok  = (dur_open >= 52'(target));
    sts.seg_full  = (seg_count >= SEG_CW'(WINDOW_DEPTH));
    sts.cnt_gt1   = (seg_count > SEG_CW'(1));
    sts.evict     = rest[56] || (rest[55:0] > 56'(limit));
    sts.kc_neg    = keep[4];
    sts.kc_lt_cnt = !keep[4] && ((SEG_CW + 1)'(unsigned'(keep[3:0])) <
                                 (SEG_CW + 1)'(seg_count));
    sts.ret_nz    = (ret_count != '0);
    sts.expired   = (ret_q.keep_to < seg_q.start);
  end

  always_comb begin
    case (cmd.op)
      OP_CAPF:   seg_ra = sts.kc_lt_cnt
                          ? seg_add(seg_head, SEG_CW'(unsigned'(keep[3:0])))
                          : seg_add(seg_head, seg_count - 1'b1);
      OP_RD_IDX: seg_ra = seg_add(seg_head, SEG_CW'(req_q.entry_index));
      default:   seg_ra = seg_head;
    endcase
    seg_we         = (cmd.op == OP_WRITE_SEG);
    seg_wa         = seg_add(seg_head, seg_count);
    seg_wd.start   = open_start;
    seg_wd.dur     = dur_open;
    seg_wd.seq     = open_seq;
    ret_we         = (cmd.op == OP_PUSH_POP);
    ret_wa         = ret_add(ret_head, ret_count);
    ret_wd.start   = f_start;
    ret_wd.keep_to = keep_to;
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_q <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (ret_we) ret_mem[ret_wa] <= ret_wd;
    ret_q <= ret_mem[ret_head];
  end

  always_comb begin
    emit    = 1'b0;
    new_res = '0;
    new_res.entry_count = 5'(seg_count);
    case (cmd.op)
      OP_RET_EMIT: begin
        emit            = hold;
        new_res.action  = ACT_MOVE;
        new_res.time_us = (ret_count != '0) ? ret_q.start : seg_q.start;
      end
      OP_HOLD: begin
        emit            = !hold;
        new_res.action  = ACT_START;
        new_res.time_us = req_q.frame_time_us;
      end
      OP_CLEAR: begin
        emit                = hold;
        new_res.action      = ACT_RELEASE;
        new_res.entry_count = '0;
      end
      OP_ENTRY: begin
        emit           = 1'b1;
        new_res.action = ACT_ENTRY;
        if (idx_lt_cnt) begin
          new_res.time_us           = seg_q.start;
          new_res.entry_duration_us = seg_q.dur;
          new_res.entry_sequence    = seg_q.seq;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    pend_fin      = pend;
    pend_fin.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target        <= 32'd10000000;
      keep          <= -5'sd1;
      seg_head      <= '0;
      seg_count     <= '0;
      ret_head      <= '0;
      ret_count     <= '0;
      total         <= '0;
      open_start    <= '0;
      open_seq      <= '0;
      seq_cnt       <= '0;
      hold          <= 1'b0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET: target <= cfg_data;
          CFG_KEEP:   keep   <= signed'(cfg_data[4:0]);
          default:    target <= target;
        endcase
      end

      result_strobe <= pend_v && (emit || cmd.op == OP_FLUSH);
      if (emit) begin
        pend   <= new_res;
        pend_v <= 1'b1;
        if (pend_v) begin
          result <= pend;
        end
      end else if (cmd.op == OP_FLUSH && pend_v) begin
        result <= pend_fin;
        pend_v <= 1'b0;
      end

      case (cmd.op)
        OP_LATCH: begin
          req_q <= req;
          bak   <= total;
        end
        OP_POP_FULL: begin
          total     <= total - 56'(seg_q.dur);
          seg_head  <= seg_inc(seg_head);
          seg_count <= seg_count - 1'b1;
        end
        OP_WRITE_SEG: begin
          seg_count <= seg_count + 1'b1;
          total     <= total + 56'(dur_open);
          open_seq  <= '0;
        end
        OP_CAPF: begin
          f_start <= seg_q.start;
          f_dur   <= seg_q.dur;
        end
        OP_UNTIL_SPEC: keep_to <= sat52(spec_sum);
        OP_UNTIL_KEEP: keep_to <= seg_q.start;
        OP_MUL: begin
          prod <= 56'(f_dur) * 56'(kc_diff[3:0]);
          tsum <= 53'(seg_q.start) + 53'(seg_q.dur);
        end
        OP_UNTIL_TAIL: keep_to <= sat52(tail_sum);
        OP_PUSH_POP: begin
          if (ret_full) begin
            ret_head <= ret_inc(ret_head);
          end else begin
            ret_count <= ret_count + 1'b1;
          end
          total     <= total - 56'(f_dur);
          seg_head  <= seg_inc(seg_head);
          seg_count <= seg_count - 1'b1;
        end
        OP_RET_POP: begin
          ret_head  <= ret_inc(ret_head);
          ret_count <= ret_count - 1'b1;
        end
        OP_OPEN: begin
          if (open_seq == '0) begin
            open_start <= req_q.frame_time_us;
            seq_cnt    <= seq_inc;
            open_seq   <= seq_inc;
          end
        end
        OP_HOLD: hold <= 1'b1;
        OP_CLEAR: begin
          total     <= '0;
          seg_head  <= '0;
          seg_count <= '0;
          ret_head  <= '0;
          ret_count <= '0;
          hold      <= 1'b0;
        end
        default: hold <= hold;
      endcase
    end
  end

endmodule

// File: rtl/live_segment_window_manager.sv
// Top level of the live segment window manager: sequencer, datapath and checks.
//
//   channel   signals                          transfer when
//   request   start, busy, request             start && !busy
//   result    result_strobe, result            result_strobe (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_index,  cfg_valid && cfg_ready
//             cfg_data
//
// One item at a time: a new request is taken only while busy is low. A closing keyframe
// also pops the oldest segment when the window is full, walks each evicted segment (with
// a multiply step for the keep-count tail rule) and each expired retention pair in turn,
// set by the single read port of each ring.
// The final result, with last set, shows in the first idle cycle.
// Reset is synchronous; both rings start empty, the hold inactive.
module live_segment_window_manager (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lswm_pkg::req_t  request,
  output logic            result_strobe,
  output lswm_pkg::res_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);
  import lswm_pkg::*;
  `include "live_segment_window_manager_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = !busy;

  lswm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lswm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req           (request),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sts           (sts),
    .result        (result),
    .result_strobe (result_strobe)
  );

  `LSWM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `LSWM_ASSERT_NOW(a_idle_last, result_strobe && !busy, result.last, "idle result without last")
  `LSWM_ASSERT_NEXT(a_last_gap, result_strobe && result.last, !result_strobe, "result after last")
  `LSWM_ASSERT_NOW(a_count_range, result_strobe, result.entry_count <= 5'(WINDOW_DEPTH),
                   "entry count beyond window depth")

endmodule

// File: dv/live_segment_window_manager_test.sv
// Self-checking testbench for the live segment window manager: random and directed requests.
`timescale 1ns / 100ps

module live_segment_window_manager_test;
  import lswm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [63:0] M52 = (64'd1 << 52) - 64'd1;
  localparam logic [63:0] M56 = (64'd1 << 56) - 64'd1;
  localparam int DRAIN_CYCLES = 250;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int DUE_DEPTH = 64;

  class window_scoreboard;
    logic [51:0] win_start [WINDOW_DEPTH];
    logic [51:0] win_dur [WINDOW_DEPTH];
    logic [31:0] win_seq [WINDOW_DEPTH];
    int          win_head, win_cnt;
    logic [51:0] ret_start [RETAIN_DEPTH];
    logic [51:0] ret_until [RETAIN_DEPTH];
    int          ret_head, ret_cnt;
    logic [63:0] total_us;
    logic [51:0] open_start;
    logic [31:0] open_seq, seq_ctr;
    bit          hold_on;
    logic [31:0] target_us;
    int          keep;
    res_t        due_q [DUE_DEPTH];
    int          due_rd, due_wr;
    int          errors;

    function new();
      win_head = 0; win_cnt = 0; ret_head = 0; ret_cnt = 0;
      total_us = 0; open_start = 0; open_seq = 0; seq_ctr = 0;
      hold_on = 0; target_us = 32'd10000000; keep = -1; errors = 0;
      due_rd = 0; due_wr = 0;
    endfunction

    function int pending();
      return due_wr - due_rd;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_TARGET) target_us = data;
      else keep = $signed(data[4:0]);
    endfunction

    function void emit(logic [1:0] act, logic [51:0] t, logic [51:0] d, logic [31:0] s);
      res_t x;
      x.action = act;
      x.time_us = t;
      x.entry_duration_us = d;
      x.entry_sequence = s;
      x.entry_count = win_cnt[4:0];
      x.last = 1'b0;
      due_q[due_wr % DUE_DEPTH] = x;
      due_wr++;
    endfunction

    function void drop_oldest_seg();
      total_us = (total_us - {12'd0, win_dur[win_head]}) & M56;
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_cnt--;
    endfunction

    function void push_retention(logic [51:0] s, logic [51:0] u);
      int pos;
      if (ret_cnt >= RETAIN_DEPTH) begin
        ret_head = (ret_head + 1) % RETAIN_DEPTH;
        ret_cnt--;
      end
      pos = (ret_head + ret_cnt) % RETAIN_DEPTH;
      ret_start[pos] = s;
      ret_until[pos] = u;
      ret_cnt++;
    endfunction

    function void close_seg(logic [51:0] dur);
      logic [63:0] bak, lim, keep_to;
      int pos, f, b;
      bak = total_us;
      lim = {32'd0, target_us} * 64'd3;
      if (win_cnt >= WINDOW_DEPTH) drop_oldest_seg();
      pos = (win_head + win_cnt) % WINDOW_DEPTH;
      win_start[pos] = open_start;
      win_dur[pos] = dur;
      win_seq[pos] = open_seq;
      win_cnt++;
      total_us = (total_us + {12'd0, dur}) & M56;
      open_seq = 0;
      while (win_cnt > 1) begin
        f = win_head;
        if (total_us - {12'd0, win_dur[f]} <= lim) break;
        if (keep < 0) begin
          keep_to = {12'd0, win_start[f]} + 64'd2 * {12'd0, win_dur[f]} + bak;
        end else if (keep < win_cnt) begin
          keep_to = {12'd0, win_start[(win_head + keep) % WINDOW_DEPTH]};
        end else begin
          b = (win_head + win_cnt - 1) % WINDOW_DEPTH;
          keep_to = {12'd0, win_start[b]} + {12'd0, win_dur[b]}
                  + {12'd0, win_dur[f]} * 64'(keep - win_cnt);
        end
        push_retention(win_start[f], (keep_to > M52) ? M52[51:0] : keep_to[51:0]);
        drop_oldest_seg();
      end
      while (ret_cnt > 0 && ret_until[ret_head] < win_start[win_head]) begin
        ret_head = (ret_head + 1) % RETAIN_DEPTH;
        ret_cnt--;
        if (hold_on)
          emit(ACT_MOVE, (ret_cnt > 0) ? ret_start[ret_head] : win_start[win_head],
               52'd0, 32'd0);
      end
    endfunction

    // predicts the results of one accepted request
    function void note_request(req_t r);
      logic [51:0] dur;
      int p;
      int first_wr;
      first_wr = due_wr;
      case (r.req_type)
        REQ_KEY: begin
          if (open_seq != 0) begin
            dur = r.frame_time_us - open_start;
            if ({12'd0, dur} >= {32'd0, target_us}) close_seg(dur);
          end
          if (open_seq == 0) begin
            open_start = r.frame_time_us;
            seq_ctr++;
            if (seq_ctr == 0) seq_ctr = 1;
            open_seq = seq_ctr;
          end
          if (!hold_on) begin
            hold_on = 1'b1;
            emit(ACT_START, r.frame_time_us, 52'd0, 32'd0);
          end
        end
        REQ_CLEAR: begin
          total_us = 0; win_head = 0; win_cnt = 0; ret_head = 0; ret_cnt = 0;
          if (hold_on) begin
            hold_on = 1'b0;
            emit(ACT_RELEASE, 52'd0, 52'd0, 32'd0);
          end
        end
        REQ_READ: begin
          if (r.entry_index < win_cnt) begin
            p = (win_head + r.entry_index) % WINDOW_DEPTH;
            emit(ACT_ENTRY, win_start[p], win_dur[p], win_seq[p]);
          end else begin
            emit(ACT_ENTRY, 52'd0, 52'd0, 32'd0);
          end
        end
        default: ;
      endcase
      if (due_wr != first_wr) due_q[(due_wr - 1) % DUE_DEPTH].last = 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (due_wr == due_rd) begin
        $error("unexpected result action=%0d time=%0h", got.action, got.time_us);
        errors++;
        return;
      end
      exp = due_q[due_rd % DUE_DEPTH];
      due_rd++;
      if (got.action !== exp.action) begin
        $error("action: expected %0h actual %0h", exp.action, got.action); errors++;
      end
      if (got.time_us !== exp.time_us) begin
        $error("time_us: expected %0h actual %0h", exp.time_us, got.time_us); errors++;
      end
      if (got.entry_duration_us !== exp.entry_duration_us) begin
        $error("entry_duration_us: expected %0h actual %0h",
               exp.entry_duration_us, got.entry_duration_us); errors++;
      end
      if (got.entry_sequence !== exp.entry_sequence) begin
        $error("entry_sequence: expected %0h actual %0h",
               exp.entry_sequence, got.entry_sequence); errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0h actual %0h", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0h actual %0h", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, result_strobe;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  req_t        request;
  res_t        result;

  window_scoreboard sb;
  longint      cycles;
  int          gap_ahead;
  bit          burst;
  logic [63:0] frame_clock;

  live_segment_window_manager i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("live_segment_window_manager: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && result_strobe) sb.check_result(result);
  end

  function int draw_gap();
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return int'($urandom_range(0, 18));
  endfunction

  // start stays high into the next request when no gap follows
  task send(req_t r, bit more);
    bit acc;
    repeat (gap_ahead) @(posedge clk);
    start <= 1'b1;
    request <= r;
    do begin
      @(negedge clk);
      acc = !busy;
      @(posedge clk);
    end while (!acc);
    sb.note_request(r);
    gap_ahead = draw_gap();
    if (gap_ahead != 0 || !more) start <= 1'b0;
  endtask

  task settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [31:0] data);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function req_t mk(logic [1:0] kind, logic [51:0] t, logic [3:0] idx);
    req_t r;
    r.req_type = kind;
    r.frame_time_us = t;
    r.entry_index = idx;
    return r;
  endfunction

  function req_t random_request();
    int roll;
    logic [63:0] tgt;
    roll = $urandom_range(0, 99);
    tgt = {32'd0, sb.target_us};
    if (roll < 3) return mk(REQ_CLEAR, 52'({$urandom, $urandom}), 4'($urandom));
    if (roll < 5) return mk(REQ_UNUSED, 52'({$urandom, $urandom}), 4'($urandom));
    if (roll < 25) return mk(REQ_READ, 52'({$urandom, $urandom}), 4'($urandom));
    if (roll < 28) begin
      frame_clock = 64'({$urandom, $urandom}) & M52;
    end else if (tgt == 0) begin
      frame_clock = (frame_clock
                  + 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0)) & M52;
    end else begin
      frame_clock = (frame_clock + tgt * 64'($urandom_range(0, 250)) / 64'd100) & M52;
    end
    return mk(REQ_KEY, frame_clock[51:0], 4'($urandom));
  endfunction

  task random_phase(int n);
    req_t r;
    int counted;
    counted = 0;
    burst = ($urandom_range(0, 3) == 0);
    while (counted < n) begin
      r = random_request();
      if (r.req_type != REQ_UNUSED) counted++;
      send(r, counted < n);
    end
    settle();
  endtask

  logic [31:0] targets [8];
  int          keeps [8];

  initial begin
    sb = new();
    cycles = 0;
    gap_ahead = 0;
    burst = 0;
    frame_clock = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TARGET;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then extremes
    send(mk(REQ_READ, 52'd0, 4'd0), 1'b1);
    send(mk(REQ_KEY, 52'd0, 4'hF), 1'b1);
    send(mk(REQ_KEY, 52'd5000000, 4'd0), 1'b1);
    send(mk(REQ_KEY, 52'd10000000, 4'd0), 1'b1);
    send(mk(REQ_KEY, M52[51:0], 4'd0), 1'b1);
    send(mk(REQ_KEY, 52'd3, 4'd0), 1'b1);
    send(mk(REQ_READ, M52[51:0], 4'd0), 1'b1);
    send(mk(REQ_READ, 52'd0, 4'd1), 1'b1);
    send(mk(REQ_READ, 52'd0, 4'd15), 1'b1);
    send(mk(REQ_UNUSED, M52[51:0], 4'hF), 1'b1);
    send(mk(REQ_CLEAR, 52'd0, 4'd0), 1'b1);
    send(mk(REQ_CLEAR, M52[51:0], 4'hF), 1'b0);
    settle();
    write_reg(CFG_TARGET, 32'd0);
    write_reg(CFG_KEEP, 32'h0000_000F);
    for (int i = 0; i < 20; i++) send(mk(REQ_KEY, 52'd100, 4'd0), 1'b1);
    send(mk(REQ_READ, 52'd0, 4'd15), 1'b1);
    send(mk(REQ_KEY, 52'd50, 4'd0), 1'b1);
    send(mk(REQ_READ, 52'd0, 4'd15), 1'b0);
    settle();

    targets = '{32'd10000000, 32'd1000, 32'd7, 32'd500, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd300};
    keeps = '{-1, 0, 3, -1, 15, -1, 15, -16};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_TARGET, targets[ph]);
      write_reg(CFG_KEEP, 32'(keeps[ph]));
      if ($urandom_range(0, 1) == 0) send(mk(REQ_CLEAR, 52'd0, 4'd0), 1'b0);
      random_phase(36);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("live_segment_window_manager: match");
    end else begin
      $display("live_segment_window_manager: mismatch");
    end
    $finish;
  end
endmodule
